@@ rtl/sktr_pkg.sv @@
// ----------------------------------------------------------------------------
// sktr_pkg: shared types for the streaming k-smallest tracker
// Holds the request and result payload structs, the register width and the
// sequencer state encoding.
// ----------------------------------------------------------------------------
package sktr_pkg;

  localparam int VAL_W = 32;
  localparam int K_W   = 5;

  // Flipping the sign bit makes unsigned order match signed order.
  localparam logic [VAL_W-1:0] SIGN_BIAS = 32'h8000_0000;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    set_end;
  } item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] kept_value;
    logic                    run_last;
    logic                    empty_res;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_REP_RD0,
    ST_REP_CMP0,
    ST_REP_RD,
    ST_REP_CMP,
    ST_DONE,
    ST_EMPTY,
    ST_OUT_RD,
    ST_OUT_LD
  } state_t;

endpackage

@@ rtl/sktr_out_stage.sv @@
// ----------------------------------------------------------------------------
// sktr_out_stage: result output register
// Holds one result until the receiver takes it and reports when a new
// result can be loaded in the same cycle.
// ----------------------------------------------------------------------------
module sktr_out_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  sktr_pkg::res_t load_data,
  output logic          free,
  output logic          res_valid,
  input  logic          res_ready,
  output sktr_pkg::res_t res
);
  import sktr_pkg::*;

  // The register can take a new result when empty or being drained now.
  assign free = !res_valid || res_ready;

  // Valid flag: set on load, cleared when the result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      res <= load_data;
    end
  end

endmodule

@@ rtl/streaming_k_smallest_tracker.sv @@
// ----------------------------------------------------------------------------
// streaming_k_smallest_tracker: keeps the k smallest values of a data set
// Sorted store walked by one shared compare unit under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item) takes one signed value per
//   request; item.set_end marks the last value of a data set.
//   res channel (res_valid/res_ready/res) returns the k smallest values (k capped at K_MAX) of
//   the set, largest first, run_last on the final one, or one result with
//   empty_res set when fewer than k values arrived or k is zero.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes k_count; it is always
//   ready; the user must write it only while the block is idle (not enforced).
// Flow:
//   A value holds the item channel while it is dropped, inserted or put in
//   place of the largest entry; stored entries move one at a time, as the
//   one-port store and the single comparator give one entry read and then
//   one compare per entry. On set_end the results follow once that value
//   is done (the empty result likewise); each result is read from the store
//   and then loaded, waiting while the receiver stalls; the last result
//   sits in the output register while the next set is taken in.
// Reset clears the fill count, the sequencer and the output valid, and sets
// k_count to 1; the store contents need no reset.
module streaming_k_smallest_tracker #(
  parameter int K_MAX = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  sktr_pkg::item_t               item,
  output logic                          res_valid,
  input  logic                          res_ready,
  output sktr_pkg::res_t                res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sktr_pkg::K_W-1:0]      cfg_data
);
  import sktr_pkg::*;

  localparam int IW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int CW = $clog2(K_MAX + 1);

  state_t           state, state_next;
  logic [K_W-1:0]   k_count;
  logic [CW-1:0]    fill, fill_next;
  logic [CW-1:0]    ptr, ptr_next;
  logic [CW-1:0]    out_idx, out_idx_next;
  logic [CW-1:0]    out_end, out_end_next;
  logic [VAL_W-1:0] key, key_next;
  logic             last, last_next;
  logic [CW-1:0]    keff;
  logic [CW-1:0]    ptr_m1, ptr_p1;

  logic [VAL_W-1:0] mem [K_MAX];
  logic             mem_we, mem_re;
  logic [CW-1:0]    mem_waddr, mem_raddr;
  logic [VAL_W-1:0] mem_wdata, rdata;

  logic             out_load, out_free;
  res_t             out_data;

  // Configuration register; the port never stalls.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      k_count <= K_W'(1);
    end else if (cfg_valid) begin
      k_count <= cfg_data;
    end
  end

  // Effective k saturates at the store depth.
  assign keff = (int'(k_count) > K_MAX) ? CW'(K_MAX) : CW'(k_count);

  assign ptr_m1 = ptr - 1'b1;
  assign ptr_p1 = ptr + 1'b1;

  assign item_ready = (state == ST_IDLE);

  // Sorted store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr[IW-1:0]] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata <= mem[mem_raddr[IW-1:0]];
    end
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr     <= ptr_next;
    out_idx <= out_idx_next;
    out_end <= out_end_next;
    key     <= key_next;
    last    <= last_next;
  end

  // Next state, store accesses and result loads.
  always_comb begin
    state_next   = state;
    fill_next    = fill;
    ptr_next     = ptr;
    out_idx_next = out_idx;
    out_end_next = out_end;
    key_next     = key;
    last_next    = last;
    mem_we       = 1'b0;
    mem_waddr    = ptr;
    mem_wdata    = key;
    mem_re       = 1'b0;
    mem_raddr    = ptr;
    out_load     = 1'b0;
    out_data     = '{kept_value: $signed(rdata ^ SIGN_BIAS), run_last: 1'b0,
                     empty_res: 1'b0};

    unique case (state)
      // Take a value and pick insertion, replacement or nothing.
      ST_IDLE: begin
        if (item_valid) begin
          key_next  = item.value ^ SIGN_BIAS;
          last_next = item.set_end;
          ptr_next  = fill;
          if (fill < keff) begin
            state_next = ST_INS_RD;
          end else if (fill != '0) begin
            state_next = ST_REP_RD0;
          end else begin
            state_next = ST_DONE;
          end
        end
      end

      // Insertion walks down from the free slot, moving smaller entries up.
      ST_INS_RD: begin
        if (ptr == '0) begin
          mem_we     = 1'b1;
          fill_next  = fill + 1'b1;
          state_next = ST_DONE;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = ptr_m1;
          state_next = ST_INS_CMP;
        end
      end

      ST_INS_CMP: begin
        mem_we = 1'b1;
        if (rdata < key) begin
          mem_wdata  = rdata;
          ptr_next   = ptr_m1;
          state_next = ST_INS_RD;
        end else begin
          fill_next  = fill + 1'b1;
          state_next = ST_DONE;
        end
      end

      // Replacement first checks the largest kept entry.
      ST_REP_RD0: begin
        mem_re     = 1'b1;
        mem_raddr  = '0;
        state_next = ST_REP_CMP0;
      end

      ST_REP_CMP0: begin
        ptr_next = '0;
        if (key < rdata) begin
          state_next = ST_REP_RD;
        end else begin
          state_next = ST_DONE;
        end
      end

      // The largest entry drops out; entries not below the key move down.
      ST_REP_RD: begin
        if (ptr_p1 >= fill) begin
          mem_we     = 1'b1;
          state_next = ST_DONE;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = ptr_p1;
          state_next = ST_REP_CMP;
        end
      end

      ST_REP_CMP: begin
        mem_we = 1'b1;
        if (rdata >= key) begin
          mem_wdata  = rdata;
          ptr_next   = ptr_p1;
          state_next = ST_REP_RD;
        end else begin
          state_next = ST_DONE;
        end
      end

      // Return to idle, or at the end of a set choose the report and clear the fill count.
      ST_DONE: begin
        if (!last) begin
          state_next = ST_IDLE;
        end else begin
          fill_next    = '0;
          out_idx_next = fill - keff;
          out_end_next = fill - 1'b1;
          if (keff == '0 || fill < keff) begin
            state_next = ST_EMPTY;
          end else begin
            state_next = ST_OUT_RD;
          end
        end
      end

      ST_EMPTY: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_data   = '{kept_value: '0, run_last: 1'b1, empty_res: 1'b1};
          state_next = ST_IDLE;
        end
      end

      // Read one kept entry once the output register can take it.
      ST_OUT_RD: begin
        if (out_free) begin
          mem_re     = 1'b1;
          mem_raddr  = out_idx;
          state_next = ST_OUT_LD;
        end
      end

      ST_OUT_LD: begin
        out_load          = 1'b1;
        out_data.run_last = (out_idx == out_end);
        if (out_idx == out_end) begin
          state_next = ST_IDLE;
        end else begin
          out_idx_next = out_idx + 1'b1;
          state_next   = ST_OUT_RD;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register toward the receiver.
  sktr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (out_load),
    .load_data (out_data),
    .free      (out_free),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule
